>>> rtl/rectangle_subtract_assert.svh
// Assertion macros shared by the rectangle_subtract checker.
// No dependencies; include by bare file name.
`ifndef RECTANGLE_SUBTRACT_ASSERT_SVH
`define RECTANGLE_SUBTRACT_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define RS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rectangle_subtract: same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define RS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rectangle_subtract: next-cycle check failed");

`endif

>>> rtl/rs_pkg.sv
// Types and constants for rectangle_subtract.
// No dependencies.
package rs_pkg;

	localparam int EDGE_W     = 16;
	localparam int NUM_PIECES = 4;
	localparam int PIECE_IDX_W = $clog2(NUM_PIECES);

	// slot order of the pieces, also their output order
	localparam logic [PIECE_IDX_W-1:0] SLOT_LEFT   = 2'd0;
	localparam logic [PIECE_IDX_W-1:0] SLOT_TOP    = 2'd1;
	localparam logic [PIECE_IDX_W-1:0] SLOT_RIGHT  = 2'd2;
	localparam logic [PIECE_IDX_W-1:0] SLOT_BOTTOM = 2'd3;

	localparam logic signed [EDGE_W-1:0] EDGE_ONE = 16'sd1;

	// inclusive rectangle, left edge in the low bits
	typedef struct packed {
		logic signed [EDGE_W-1:0] bottom;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] top;
		logic signed [EDGE_W-1:0] left;
	} rect_t;

	// one result word: rectangle plus empty flag in the top bit
	typedef struct packed {
		logic  empty;
		rect_t box;
	} piece_t;

	localparam int RECT_W = $bits(rect_t);

endpackage

>>> rtl/rectangle_subtract.sv
// Input word, pieces and result words are held in the input, piece and output registers.
// One input word per cycle while items give one word each and m_tready is high; each item
// gives 1 to 4 result words, one per cycle while m_tready is high, so output sets the rate.
// Input register, piece register and output register decouple the two sides.
// Reset (arst_n low, asynchronous) empties all three stages; no other state.
// Depends on rs_pkg.
module rectangle_subtract
	import rs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// slave side
	input  logic                s_tvalid,
	output logic                s_tready,
	// a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom (16 bits each)
	input  logic [2*RECT_W-1:0] s_tdata,
	// master side
	output logic                m_tvalid,
	input  logic                m_tready,
	// piece_left, piece_top, piece_right, piece_bottom (16 bits each)
	output logic [RECT_W-1:0]   m_tdata,
	// nothing_left
	output logic                m_tuser,
	// last_piece
	output logic                m_tlast
);

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic  valid_s1;
	rect_t a_s1, b_s1;
	logic  load_s1, load_s2;

	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			a_s1 <= rect_t'(s_tdata[RECT_W-1:0]);
			b_s1 <= rect_t'(s_tdata[2*RECT_W-1:RECT_W]);
		end
	end

	// ---------------------------------------------------------------
	// Piece computation: all four candidate pieces side by side,
	// plus a mask of which ones exist.
	// ---------------------------------------------------------------
	logic                       overlap;
	logic                       has_l, has_t, has_r, has_b;
	logic signed [EDGE_W-1:0]   mid_l, mid_r;
	piece_t                     pieces_c [NUM_PIECES];
	logic [NUM_PIECES-1:0]      mask_c;

	always_comb begin
		// collapsed rectangles never overlap anything
		overlap = !(a_s1.left > a_s1.right) && !(a_s1.top > a_s1.bottom)
			&& !(b_s1.left > b_s1.right) && !(b_s1.top > b_s1.bottom)
			&& !(a_s1.left > b_s1.right) && !(a_s1.right < b_s1.left)
			&& !(a_s1.top > b_s1.bottom) && !(a_s1.bottom < b_s1.top);

		has_l = b_s1.left > a_s1.left;
		has_t = b_s1.top > a_s1.top;
		has_r = a_s1.right > b_s1.right;
		has_b = a_s1.bottom > b_s1.bottom;

		// horizontal overlap clips the top and bottom bands
		mid_l = (a_s1.left > b_s1.left) ? a_s1.left : b_s1.left;
		mid_r = (a_s1.right < b_s1.right) ? a_s1.right : b_s1.right;

		// full-height left band
		pieces_c[SLOT_LEFT].empty       = 1'b0;
		pieces_c[SLOT_LEFT].box.left    = a_s1.left;
		pieces_c[SLOT_LEFT].box.top     = a_s1.top;
		pieces_c[SLOT_LEFT].box.right   = b_s1.left - EDGE_ONE;
		pieces_c[SLOT_LEFT].box.bottom  = a_s1.bottom;
		// top band
		pieces_c[SLOT_TOP].empty        = 1'b0;
		pieces_c[SLOT_TOP].box.left     = mid_l;
		pieces_c[SLOT_TOP].box.top      = a_s1.top;
		pieces_c[SLOT_TOP].box.right    = mid_r;
		pieces_c[SLOT_TOP].box.bottom   = b_s1.top - EDGE_ONE;
		// full-height right band
		pieces_c[SLOT_RIGHT].empty      = 1'b0;
		pieces_c[SLOT_RIGHT].box.left   = b_s1.right + EDGE_ONE;
		pieces_c[SLOT_RIGHT].box.top    = a_s1.top;
		pieces_c[SLOT_RIGHT].box.right  = a_s1.right;
		pieces_c[SLOT_RIGHT].box.bottom = a_s1.bottom;
		// bottom band
		pieces_c[SLOT_BOTTOM].empty      = 1'b0;
		pieces_c[SLOT_BOTTOM].box.left   = mid_l;
		pieces_c[SLOT_BOTTOM].box.top    = b_s1.bottom + EDGE_ONE;
		pieces_c[SLOT_BOTTOM].box.right  = mid_r;
		pieces_c[SLOT_BOTTOM].box.bottom = a_s1.bottom;

		mask_c = '0;
		mask_c[SLOT_LEFT]   = has_l;
		mask_c[SLOT_TOP]    = has_t;
		mask_c[SLOT_RIGHT]  = has_r;
		mask_c[SLOT_BOTTOM] = has_b;

		if (!overlap) begin
			// no overlap: A passes through unchanged
			pieces_c[SLOT_LEFT].empty = 1'b0;
			pieces_c[SLOT_LEFT].box   = a_s1;
			mask_c                    = '0;
			mask_c[SLOT_LEFT]         = 1'b1;
		end else if (mask_c == '0) begin
			// B covers A: one empty word with zero edges
			pieces_c[SLOT_LEFT].empty = 1'b1;
			pieces_c[SLOT_LEFT].box   = '0;
			mask_c[SLOT_LEFT]         = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: piece register; mask holds the pieces not yet sent
	// ---------------------------------------------------------------
	logic                     valid_s2;
	piece_t                   pieces_s2 [NUM_PIECES];
	logic [NUM_PIECES-1:0]    mask_s2;
	logic [NUM_PIECES-1:0]    rest_mask;
	logic [PIECE_IDX_W-1:0]   sel_idx;
	logic                     out_free, send, s2_done;

	assign out_free = !m_tvalid || m_tready;
	assign send     = valid_s2 && out_free;
	// clear the lowest pending piece
	assign rest_mask = mask_s2 & (mask_s2 - 1'b1);
	assign s2_done   = send && (rest_mask == '0);
	assign load_s2   = valid_s1 && (!valid_s2 || s2_done);

	always_comb begin
		sel_idx = SLOT_LEFT;
		for (int i = NUM_PIECES - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel_idx = PIECE_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			mask_s2  <= mask_c;
		end else if (send) begin
			valid_s2 <= !s2_done;
			mask_s2  <= rest_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			pieces_s2 <= pieces_c;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic   m_tvalid_q;
	piece_t out_piece_q;
	logic   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			out_piece_q <= pieces_s2[sel_idx];
			out_last_q  <= (rest_mask == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_piece_q.box;
	assign m_tuser  = out_piece_q.empty;
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/rs_checker.sv
// Port-level checker for rectangle_subtract, bound to the top level.
// Depends on rs_pkg and rectangle_subtract_assert.svh.
`include "rectangle_subtract_assert.svh"

module rs_checker
	import rs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [RECT_W-1:0]   m_tdata,
	input logic                m_tuser,
	input logic                m_tlast
);

	// items accepted whose last word has not gone out yet
	logic [2:0] open_q;
	logic       in_acc, out_end;

	assign in_acc  = s_tvalid && s_tready;
	assign out_end = m_tvalid && m_tready && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 3'(in_acc) - 3'(out_end);
		end
	end

	`RS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`RS_ASSERT_NOW(a_empty_alone, clk, arst_n, m_tvalid && m_tuser,
		m_tlast && (m_tdata == '0))
	`RS_ASSERT_NOW(a_no_orphan_word, clk, arst_n, m_tvalid, open_q != '0)
	`RS_ASSERT_NOW(a_three_in_flight, clk, arst_n, 1'b1, open_q <= 3'd3)

endmodule

bind rectangle_subtract rs_checker u_rs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rectangle_subtract: drives rectangle pairs, predicts the remainder.
// Depends on rs_pkg and rectangle_subtract; no files, no arguments.
module tb;
	import rs_pkg::*;

	// one expected result word
	typedef struct packed {
		logic  last;
		logic  empty;
		rect_t box;
	} remainder_word_t;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int DRAIN_CYCLES = 8;	// three register stages, leave slack
	localparam int RANDOM_ITEMS = 350;
	localparam int MAX_PRINTS = 40;

	// edge values that sit on the 16-bit boundaries
	localparam logic [EDGE_W-1:0] EDGE_EXTREMES [7] = '{
		16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [2*RECT_W-1:0] s_tdata = '0;	// a_left .. a_bottom, b_left .. b_bottom
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RECT_W-1:0]   m_tdata;	// piece_left, piece_top, piece_right, piece_bottom
	logic                m_tuser;	// nothing_left
	logic                m_tlast;	// last_piece

	remainder_word_t pending_pieces [$];
	int              mismatch_count = 0;
	int              cycle_count = 0;
	int              burst_left = 0;
	logic [1:0]      stall_mode = 2'd0;

	rectangle_subtract u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit: a hang anywhere ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	function automatic rect_t mk_rect(int l, int t, int r, int b);
		rect_t q;
		q.left   = l[EDGE_W-1:0];
		q.top    = t[EDGE_W-1:0];
		q.right  = r[EDGE_W-1:0];
		q.bottom = b[EDGE_W-1:0];
		return q;
	endfunction

	// A minus B, pushed as result words in output order:
	// left band, top band, right band, bottom band
	function automatic void predict_remainder(rect_t a, rect_t b);
		logic signed [EDGE_W-1:0] al, at, ar, ab, bl, bt, br, bb, ov_left, ov_right;
		rect_t pieces [$];
		rect_t p;
		al = a.left;  at = a.top;  ar = a.right;  ab = a.bottom;
		bl = b.left;  bt = b.top;  br = b.right;  bb = b.bottom;
		// collapsed boxes never overlap anything; A passes through untouched
		if (al > ar || at > ab || bl > br || bt > bb ||
				al > br || ar < bl || at > bb || ab < bt) begin
			pending_pieces.push_back('{last: 1'b1, empty: 1'b0, box: a});
			return;
		end
		// top and bottom bands are clipped to the horizontal overlap
		ov_left  = (al > bl) ? al : bl;
		ov_right = (ar < br) ? ar : br;
		if (bl > al) begin
			p.left = al;  p.top = at;  p.right = bl - EDGE_ONE;  p.bottom = ab;
			pieces.push_back(p);
		end
		if (bt > at) begin
			p.left = ov_left;  p.top = at;  p.right = ov_right;  p.bottom = bt - EDGE_ONE;
			pieces.push_back(p);
		end
		if (ar > br) begin
			p.left = br + EDGE_ONE;  p.top = at;  p.right = ar;  p.bottom = ab;
			pieces.push_back(p);
		end
		if (ab > bb) begin
			p.left = ov_left;  p.top = bb + EDGE_ONE;  p.right = ov_right;  p.bottom = ab;
			pieces.push_back(p);
		end
		// B covers A: one flagged word with zeroed edges
		if (pieces.size() == 0)
			pending_pieces.push_back('{last: 1'b1, empty: 1'b1, box: '0});
		else
			foreach (pieces[i])
				pending_pieces.push_back('{last: (i == pieces.size() - 1), empty: 1'b0,
					box: pieces[i]});
	endfunction

	// Sends one word; called at a rising edge, returns at the edge that accepted it.
	// Valid stays up across back-to-back words; gaps only fall between bursts.
	task automatic send_pair(rect_t a, rect_t b);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			// every so often a long burst with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		predict_remainder(a, b);
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// Receiver: checks each accepted word and stalls on its own pattern.
	// Values read here are the ones that stood at the edge, since every
	// driver updates through nonblocking assignments.
	always @(posedge clk) begin
		remainder_word_t want;
		rect_t           got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_pieces.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h user %b last %b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = pending_pieces.pop_front();
				if (got.left !== want.box.left)
					report_mismatch($sformatf("piece_left %h, want %h", got.left, want.box.left));
				if (got.top !== want.box.top)
					report_mismatch($sformatf("piece_top %h, want %h", got.top, want.box.top));
				if (got.right !== want.box.right)
					report_mismatch($sformatf("piece_right %h, want %h", got.right,
						want.box.right));
				if (got.bottom !== want.box.bottom)
					report_mismatch($sformatf("piece_bottom %h, want %h", got.bottom,
						want.box.bottom));
				if (m_tuser !== want.empty)
					report_mismatch($sformatf("nothing_left %b, want %b", m_tuser, want.empty));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_piece %b, want %b", m_tlast, want.last));
			end
		end
		// new stall pattern whenever cycle_count[5:0] is zero
		if (cycle_count[5:0] == 6'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= (cycle_count[1:0] == 2'd0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// disjoint, touching and collapsed pairs: A must come back whole
	task automatic test_pass_through();
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(20, 20, 30, 30));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(-10, 0, -1, 9));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(0, 10, 9, 20));
		send_pair(mk_rect(5, 0, 4, 9), mk_rect(0, 0, 9, 9));
		send_pair(mk_rect(0, 5, 9, 4), mk_rect(0, 0, 9, 9));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(3, 3, 2, 5));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(3, 6, 5, 5));
	endtask

	// B covers A: single flagged word
	task automatic test_covered();
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(0, 0, 9, 9));
		send_pair(mk_rect(0, 0, 0, 0), mk_rect(-32768, -32768, 32767, 32767));
		send_pair(mk_rect(-32768, -32768, 32767, 32767), mk_rect(-32768, -32768, 32767, 32767));
	endtask

	// every band alone, in pairs and all four; edges on the 16-bit limits
	task automatic test_bands();
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(3, 3, 6, 6));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(-5, -5, 4, 20));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(-5, 5, 20, 20));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(5, -5, 20, 20));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(-5, -5, 20, 4));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(5, 5, 20, 20));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(-5, -5, 4, 4));
		send_pair(mk_rect(0, 0, 9, 9), mk_rect(9, -5, 20, 20));
		send_pair(mk_rect(-32768, -32768, 32767, 32767), mk_rect(0, 0, 0, 0));
		send_pair(mk_rect(-32768, -32768, 32767, 32767),
			mk_rect(-32768, -32768, -32768, -32768));
		send_pair(mk_rect(-32768, -32768, 32767, 32767), mk_rect(32767, 32767, 32767, 32767));
		send_pair(mk_rect(-32768, -32768, -1, -1), mk_rect(-2, -2, 32767, 32767));
	endtask

	// Mostly small overlapping pairs near a random origin, plus fully random
	// words, boundary edges and covering pairs.
	task automatic test_random(int count);
		int    ox, oy, al, at, ar, ab, bl, bt, br, bb;
		rect_t a, b;
		repeat (count) begin
			ox = $urandom_range(0, 64000) - 32000;
			oy = $urandom_range(0, 64000) - 32000;
			al = ox + $urandom_range(0, 15);  ar = al + $urandom_range(0, 20);
			at = oy + $urandom_range(0, 15);  ab = at + $urandom_range(0, 20);
			bl = ox + $urandom_range(0, 30);  br = bl + $urandom_range(0, 20);
			bt = oy + $urandom_range(0, 30);  bb = bt + $urandom_range(0, 20);
			case ($urandom_range(0, 9))
				6, 7: begin
					a = {$urandom, $urandom};
					b = {$urandom, $urandom};
				end
				8: begin
					a = mk_rect(al, at, ar, ab);
					b = mk_rect(al - $urandom_range(0, 5), at - $urandom_range(0, 5),
						ar + $urandom_range(0, 5), ab + $urandom_range(0, 5));
				end
				9: begin
					a = {EDGE_EXTREMES[$urandom_range(0, 6)], EDGE_EXTREMES[$urandom_range(0, 6)],
						EDGE_EXTREMES[$urandom_range(0, 6)], EDGE_EXTREMES[$urandom_range(0, 6)]};
					b = {EDGE_EXTREMES[$urandom_range(0, 6)], EDGE_EXTREMES[$urandom_range(0, 6)],
						EDGE_EXTREMES[$urandom_range(0, 6)], EDGE_EXTREMES[$urandom_range(0, 6)]};
				end
				default: begin
					a = mk_rect(al, at, ar, ab);
					b = mk_rect(bl, bt, br, bb);
				end
			endcase
			send_pair(a, b);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pass_through();
		test_covered();
		test_bands();
		test_random(RANDOM_ITEMS);

		s_tvalid <= 1'b0;
		while (pending_pieces.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/rs_pkg.sv
rtl/rectangle_subtract.sv
rtl/rs_checker.sv
test/tb.sv
